// ----- rtl/core/ps2mc_pkg.sv -----
package ps2mc_pkg;

  // register reset values and cursor home position
  localparam logic [7:0] MaxColReset = 8'd79;
  localparam logic [7:0] MaxRowReset = 8'd24;
  localparam logic [7:0] ColHome     = 8'd40;
  localparam logic [7:0] RowHome     = 8'd12;

  // header sync bit and left button bit
  localparam int unsigned SyncBit = 3;
  localparam int unsigned LeftBit = 0;

  // register indexes on the apb port
  localparam logic RegMaxCol = 1'b0;
  localparam logic RegMaxRow = 1'b1;

  // event kinds
  localparam logic EvMove  = 1'b0;
  localparam logic EvClick = 1'b1;

  // queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_e;

  // one finished packet that produces at least one item
  typedef struct packed {
    logic       moved;
    logic       click;
    logic [7:0] col;
    logic [7:0] row;
  } ev_t;

endpackage

// ----- rtl/core/ps2mc_front.sv -----
module ps2mc_front
  import ps2mc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       aux_valid_i,
  input  logic [7:0] max_col_i,
  input  logic [7:0] max_row_i,
  input  logic       q_full_i,
  output logic       push_o,
  output ev_t        push_ev_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  header_q, header_d;
  logic [7:0]  dx_q, dx_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;
  logic        btn_q, btn_d;

  logic              take;
  logic signed [8:0] dx_bias, dy_bias;
  logic signed [8:0] dx_half, dy_quart;
  logic signed [9:0] col_sum, row_sum;
  logic [7:0]        new_col, new_row;
  logic              moved, click;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o && aux_valid_i;

  // truncating divides: bias negative values before the arithmetic shift
  assign dx_bias  = $signed({dx_q[7], dx_q}) + $signed({8'b0, dx_q[7]});
  assign dy_bias  = $signed({data_byte_i[7], data_byte_i})
                  + $signed({7'b0, {2{data_byte_i[7]}}});
  assign dx_half  = dx_bias >>> 1;
  assign dy_quart = dy_bias >>> 2;

  assign col_sum = $signed({2'b00, col_q}) + $signed({dx_half[8], dx_half});
  assign row_sum = $signed({2'b00, row_q}) - $signed({dy_quart[8], dy_quart});

  // clamp to 0..max
  always_comb begin
    if (col_sum[9]) begin
      new_col = 8'd0;
    end else if (col_sum[8:0] > {1'b0, max_col_i}) begin
      new_col = max_col_i;
    end else begin
      new_col = col_sum[7:0];
    end
    if (row_sum[9]) begin
      new_row = 8'd0;
    end else if (row_sum[8:0] > {1'b0, max_row_i}) begin
      new_row = max_row_i;
    end else begin
      new_row = row_sum[7:0];
    end
  end

  assign moved = (new_col != col_q) || (new_row != row_q);
  assign click = header_q[LeftBit] && !btn_q;

  // packet assembly and cursor update
  always_comb begin
    phase_d   = phase_q;
    header_d  = header_q;
    dx_d      = dx_q;
    col_d     = col_q;
    row_d     = row_q;
    btn_d     = btn_q;
    push_o    = 1'b0;
    push_ev_o = '{moved: moved, click: click, col: new_col, row: new_row};
    if (take) begin
      case (phase_q)
        PH_DX: begin
          dx_d    = data_byte_i;
          phase_d = PH_DY;
        end
        PH_DY: begin
          phase_d = PH_HEAD;
          col_d   = new_col;
          row_d   = new_row;
          btn_d   = header_q[LeftBit];
          push_o  = moved || click;
        end
        default: begin
          // header search, bytes without the sync bit are dropped
          if (data_byte_i[SyncBit]) begin
            header_d = data_byte_i;
            phase_d  = PH_DX;
          end else begin
            phase_d  = PH_HEAD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      col_q   <= ColHome;
      row_q   <= RowHome;
      btn_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      btn_q   <= btn_d;
    end
  end

  // packet bytes need no reset
  always_ff @(posedge clk_i) begin
    header_q <= header_d;
    dx_q     <= dx_d;
  end

endmodule

// ----- rtl/core/ps2mc_queue.sv -----
module ps2mc_queue
  import ps2mc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ev_t  push_ev_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output ev_t  pop_ev_o
);

  ev_t               mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d;
  logic [QPtrW-1:0]  rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o   = (cnt_q == QCntW'(QDepth));
  assign empty_o  = (cnt_q == '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign pop_ev_o = mem_q[rd_q];

  // pointer and fill count
  always_comb begin
    wr_d  = do_push ? QPtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? QPtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = QCntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_ev_i;
    end
  end

endmodule

// ----- rtl/core/ps2mc_back.sv -----
module ps2mc_back
  import ps2mc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  ev_t         q_ev_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  col_o,
  output logic [7:0]  row_o,
  output logic        last_o
);

  logic        vld_q, vld_d;
  logic        pend_q, pend_d;
  logic        kind_q, kind_d;
  logic [7:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;
  logic        last_q, last_d;
  logic        free;

  assign free = !vld_q || out_ready_i;

  // output register load: pending click first, else next queue entry
  always_comb begin
    vld_d  = vld_q;
    pend_d = pend_q;
    kind_d = kind_q;
    col_d  = col_q;
    row_d  = row_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (free) begin
      if (pend_q) begin
        vld_d  = 1'b1;
        pend_d = 1'b0;
        kind_d = EvClick;
        last_d = 1'b1;
      end else if (!q_empty_i) begin
        pop_o  = 1'b1;
        vld_d  = 1'b1;
        col_d  = q_ev_i.col;
        row_d  = q_ev_i.row;
        if (q_ev_i.moved) begin
          kind_d = EvMove;
          last_d = !q_ev_i.click;
          pend_d = q_ev_i.click;
        end else begin
          kind_d = EvClick;
          last_d = 1'b1;
        end
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    col_q  <= col_d;
    row_q  <= row_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign col_o       = col_q;
  assign row_o       = row_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/core/ps2_mouse_packet_cursor_top.sv -----
// ps2 mouse packet decoder driving a text cursor
// input stream: one mouse port byte per item, tuser flags aux (mouse) data;
//   bytes without the flag are dropped, packets resync on header bit 3
// output stream: cursor events, tuser = kind (0 move, 1 left click),
//   tdata = {row, col}, tlast marks the final event of a packet
// apb port: max_col 0x0, max_row 0x4; user writes only while idle (unchecked)
// throughput: one byte per cycle while the queue is not full; a packet
//   with a move and a click gives two events, drained from a two entry queue
// event path: the queue is written at the edge that accepts the third byte of
//   a packet; the output register loads from the queue once it is free, and
//   the first event is offered to the receiver from that register
// reset: cursor at column 40 row 12, limits 79 and 24, button released,
//   packet search restarts, queue and output empty
// receiver stall: the output register holds; the queue absorbs two packet
//   results, then s_axis_tready drops until an entry leaves the queue
module ps2_mouse_packet_cursor_top
  import ps2mc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] aux_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] cursor_col, [15:8] cursor_row
  output logic        m_axis_tuser,   // [0] event_kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] max_col_q, max_row_q;
  logic       cfg_wr;
  logic       push, pop, q_full, q_empty;
  ev_t        push_ev, pop_ev;
  logic [7:0] out_col, out_row;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_col_q <= MaxColReset;
      max_row_q <= MaxRowReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegMaxCol: max_col_q <= pwdata[7:0];
        RegMaxRow: max_row_q <= pwdata[7:0];
        default:   max_col_q <= max_col_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegMaxCol: prdata = {24'b0, max_col_q};
      RegMaxRow: prdata = {24'b0, max_row_q};
      default:   prdata = '0;
    endcase
  end

  ps2mc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .aux_valid_i (s_axis_tuser),
    .max_col_i   (max_col_q),
    .max_row_i   (max_row_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_ev_o   (push_ev)
  );

  ps2mc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ev_i (push_ev),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .pop_i     (pop),
    .pop_ev_o  (pop_ev)
  );

  ps2mc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_ev_i      (pop_ev),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .col_o       (out_col),
    .row_o       (out_row),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {out_row, out_col};

endmodule

// ----- rtl/core/ps2mc_checker.sv -----
module ps2mc_checker
  import ps2mc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  // a click is always the final event of its packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvClick) |-> m_axis_tlast)
    else $error("click item without tlast");

  // a move that is not last is followed at once by its click at the same spot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == EvMove) && !m_axis_tlast
      |=> m_axis_tvalid && (m_axis_tuser == EvClick)
        && (m_axis_tdata == $past(m_axis_tdata)))
    else $error("move item not followed by its click");

  // output stream is empty right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind ps2_mouse_packet_cursor_top ps2mc_checker u_ps2mc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
